// File: sv/precharge_contactor_sequencer_macros.svh
// assertion macros for the precharge contactor sequencer checker
// no dependencies; each macro expects a signal named clock in scope, all but the raw one also reset

`ifndef PRECHARGE_CONTACTOR_SEQUENCER_MACROS_SVH
`define PRECHARGE_CONTACTOR_SEQUENCER_MACROS_SVH

// same-cycle implication, masked during reset
`define PCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// implication that also holds through reset
`define PCS_ASSERT_RAW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: sv/pcs_pkg.sv
// shared types and constants for the precharge contactor sequencer
// no dependencies; used by the interfaces, csr block, step logic and top level

package pcs_pkg;

   // default widths of time and voltage fields
   localparam int PCS_TIME_BITS = 32;
   localparam int PCS_VOLT_BITS = 16;

   // configuration port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // result field widths
   localparam int RELAY_W = 5;
   localparam int STAGE_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GOOD_BUS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRESH_WINDOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOST_COMM     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRECHARGE_TO  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLOSE_SETTLE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CLOSE_TO      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COOLDOWN      = 3'd6;

   // register reset values
   localparam logic [15:0] RST_GOOD_BUS     = 16'd3000;
   localparam logic [15:0] RST_FRESH_WINDOW = 16'd100;
   localparam logic [15:0] RST_LOST_COMM    = 16'd500;
   localparam logic [31:0] RST_PRECHARGE_TO = 32'd50000;
   localparam logic [15:0] RST_CLOSE_SETTLE = 16'd50;
   localparam logic [15:0] RST_CLOSE_TO     = 16'd500;
   localparam logic [15:0] RST_COOLDOWN     = 16'd1500;

   // relay patterns: bit0 precharge, bit1 right, bit2 left, bit3 distribution, bit4 fuel
   localparam logic [RELAY_W-1:0] RELAY_NONE      = 5'h00;
   localparam logic [RELAY_W-1:0] RELAY_PRECHARGE = 5'h01;
   localparam logic [RELAY_W-1:0] RELAY_CLOSING   = 5'h1F;
   localparam logic [RELAY_W-1:0] RELAY_ON        = 5'h1E;

   // bring-up stages
   typedef enum logic [STAGE_W-1:0] {
      ST_OFF       = 3'd0,
      ST_PRECHARGE = 3'd1,
      ST_CLOSING   = 3'd2,
      ST_ON        = 3'd3,
      ST_COOLDOWN  = 3'd4
   } stage_type;

   // configuration register file contents
   typedef struct packed {
      logic [15:0] good_bus_decivolts;
      logic [15:0] fresh_window_ms;
      logic [15:0] lost_comm_ms;
      logic [31:0] precharge_timeout_ms;
      logic [15:0] close_settle_ms;
      logic [15:0] close_timeout_ms;
      logic [15:0] cooldown_ms;
   } cfg_type;

   // sequencer control state, without the transition timestamp
   typedef struct packed {
      stage_type stage;
      logic      faulted;
      stage_type failed_at;
      logic      button_latch;
   } ctl_type;

   // one result beat
   typedef struct packed {
      logic [RELAY_W-1:0] relay_drive;
      logic [STAGE_W-1:0] stage_now;
      logic               fault_flag;
      logic [STAGE_W-1:0] fault_stage;
      logic               stage_changed;
   } rsp_type;

endpackage

// File: sv/pcs_if.sv
// request and response channel interfaces for the precharge contactor sequencer
// depends on pcs_pkg

interface pcs_req_if
   import pcs_pkg::*;
#(
   parameter int TIME_BITS = PCS_TIME_BITS,
   parameter int VOLT_BITS = PCS_VOLT_BITS
) ();
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] now_ms;
   logic                 button_press;
   logic                 fault_request;
   logic [TIME_BITS-1:0] right_rx_ms;
   logic [VOLT_BITS-1:0] right_bus_dv;
   logic [TIME_BITS-1:0] left_rx_ms;
   logic [VOLT_BITS-1:0] left_bus_dv;

   modport source (
      output valid, now_ms, button_press, fault_request,
             right_rx_ms, right_bus_dv, left_rx_ms, left_bus_dv,
      input  ready
   );
   modport sink (
      input  valid, now_ms, button_press, fault_request,
             right_rx_ms, right_bus_dv, left_rx_ms, left_bus_dv,
      output ready
   );
endinterface

interface pcs_rsp_if
   import pcs_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [RELAY_W-1:0] relay_drive;
   logic [STAGE_W-1:0] stage_now;
   logic               fault_flag;
   logic [STAGE_W-1:0] fault_stage;
   logic               stage_changed;

   modport source (
      output valid, relay_drive, stage_now, fault_flag, fault_stage, stage_changed,
      input  ready
   );
   modport sink (
      input  valid, relay_drive, stage_now, fault_flag, fault_stage, stage_changed,
      output ready
   );
endinterface

// File: sv/pcs_csr.sv
// apb-style configuration registers for the precharge contactor sequencer
// depends on pcs_pkg

module pcs_csr
   import pcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type              cfg_ff;
   logic                 wr_en;
   logic [CSR_IDX_W-1:0] reg_idx;

   // word index from the byte address
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register writes, access phase only
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.good_bus_decivolts   <= RST_GOOD_BUS;
         cfg_ff.fresh_window_ms      <= RST_FRESH_WINDOW;
         cfg_ff.lost_comm_ms         <= RST_LOST_COMM;
         cfg_ff.precharge_timeout_ms <= RST_PRECHARGE_TO;
         cfg_ff.close_settle_ms      <= RST_CLOSE_SETTLE;
         cfg_ff.close_timeout_ms     <= RST_CLOSE_TO;
         cfg_ff.cooldown_ms          <= RST_COOLDOWN;
      end else if (wr_en) begin
         case (reg_idx)
            REG_GOOD_BUS:     cfg_ff.good_bus_decivolts   <= csr_pwdata[15:0];
            REG_FRESH_WINDOW: cfg_ff.fresh_window_ms      <= csr_pwdata[15:0];
            REG_LOST_COMM:    cfg_ff.lost_comm_ms         <= csr_pwdata[15:0];
            REG_PRECHARGE_TO: cfg_ff.precharge_timeout_ms <= csr_pwdata[31:0];
            REG_CLOSE_SETTLE: cfg_ff.close_settle_ms      <= csr_pwdata[15:0];
            REG_CLOSE_TO:     cfg_ff.close_timeout_ms     <= csr_pwdata[15:0];
            REG_COOLDOWN:     cfg_ff.cooldown_ms          <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read mux, unmapped words read zero
   always_comb begin
      case (reg_idx)
         REG_GOOD_BUS:     csr_prdata = {16'd0, cfg_ff.good_bus_decivolts};
         REG_FRESH_WINDOW: csr_prdata = {16'd0, cfg_ff.fresh_window_ms};
         REG_LOST_COMM:    csr_prdata = {16'd0, cfg_ff.lost_comm_ms};
         REG_PRECHARGE_TO: csr_prdata = cfg_ff.precharge_timeout_ms;
         REG_CLOSE_SETTLE: csr_prdata = {16'd0, cfg_ff.close_settle_ms};
         REG_CLOSE_TO:     csr_prdata = {16'd0, cfg_ff.close_timeout_ms};
         REG_COOLDOWN:     csr_prdata = {16'd0, cfg_ff.cooldown_ms};
         default:          csr_prdata = '0;
      endcase
   end

endmodule

// File: sv/pcs_step.sv
// one poll of the bring-up sequencer: next control state and result beat
// depends on pcs_pkg; purely combinational, registered by the top level

module pcs_step
   import pcs_pkg::*;
#(
   parameter int TIME_BITS = PCS_TIME_BITS,
   parameter int VOLT_BITS = PCS_VOLT_BITS
) (
   input  cfg_type              cfg,
   input  ctl_type              ctl_cur,
   input  logic [TIME_BITS-1:0] last_ms_cur,
   input  logic [TIME_BITS-1:0] now_ms,
   input  logic                 button_press,
   input  logic                 fault_request,
   input  logic [TIME_BITS-1:0] right_rx_ms,
   input  logic [VOLT_BITS-1:0] right_bus_dv,
   input  logic [TIME_BITS-1:0] left_rx_ms,
   input  logic [VOLT_BITS-1:0] left_bus_dv,
   output ctl_type              ctl_nxt,
   output logic [TIME_BITS-1:0] last_ms_nxt,
   output rsp_type              rsp
);

   // compare widths: wide enough for both the age and the 32-bit timeout
   localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int VW = (VOLT_BITS > 16) ? VOLT_BITS : 16;

   logic [TIME_BITS-1:0] r_age;
   logic [TIME_BITS-1:0] l_age;
   logic [CW-1:0]        r_age_w;
   logic [CW-1:0]        l_age_w;
   logic [VW-1:0]        r_v_w;
   logic [VW-1:0]        l_v_w;
   logic [VW-1:0]        thr_w;
   logic                 fresh;
   logic                 hot;
   logic                 lost;
   logic [TIME_BITS-1:0] since_last;
   logic [CW-1:0]        elapsed;
   logic                 changed;
   logic [RELAY_W-1:0]   relays;

   // telemetry ages and voltage tests
   assign r_age   = now_ms - right_rx_ms;
   assign l_age   = now_ms - left_rx_ms;
   assign r_age_w = CW'(r_age);
   assign l_age_w = CW'(l_age);
   assign r_v_w   = VW'(right_bus_dv);
   assign l_v_w   = VW'(left_bus_dv);
   assign thr_w   = VW'(cfg.good_bus_decivolts);

   assign fresh = (r_age_w < CW'(cfg.fresh_window_ms)) && (l_age_w < CW'(cfg.fresh_window_ms));
   assign hot   = (r_v_w > thr_w) && (l_v_w > thr_w);
   assign lost  = (r_age_w > CW'(cfg.lost_comm_ms)) || (r_v_w < thr_w) ||
                  (l_age_w > CW'(cfg.lost_comm_ms)) || (l_v_w < thr_w);

   // stage rules, applied in order
   always_comb begin
      ctl_nxt              = ctl_cur;
      last_ms_nxt          = last_ms_cur;
      changed              = 1'b0;
      ctl_nxt.button_latch = ctl_cur.button_latch | button_press;

      // external fault request goes first
      if (fault_request) begin
         ctl_nxt.faulted   = 1'b1;
         ctl_nxt.failed_at = ctl_cur.stage;
         ctl_nxt.stage     = ST_COOLDOWN;
         last_ms_nxt       = now_ms;
         changed           = 1'b1;
      end

      // time in the current stage, after any request restart; wraps at the time width
      since_last = now_ms - last_ms_nxt;
      elapsed    = CW'(since_last);

      // relays follow the stage after any fault request, before the stage rules
      case (ctl_nxt.stage)
         ST_PRECHARGE: relays = RELAY_PRECHARGE;
         ST_CLOSING:   relays = RELAY_CLOSING;
         ST_ON:        relays = RELAY_ON;
         default:      relays = RELAY_NONE;
      endcase

      case (ctl_nxt.stage)
         ST_OFF: begin
            if (ctl_nxt.button_latch) begin
               ctl_nxt.button_latch = 1'b0;
               ctl_nxt.faulted      = 1'b0;
               ctl_nxt.stage        = ST_PRECHARGE;
               last_ms_nxt          = now_ms;
               changed              = 1'b1;
            end
         end
         ST_PRECHARGE: begin
            // advancing resets the timer, so the timeout cannot also fire
            if (fresh && hot) begin
               ctl_nxt.faulted = 1'b0;
               ctl_nxt.stage   = ST_CLOSING;
               last_ms_nxt     = now_ms;
               changed         = 1'b1;
            end else if (elapsed > CW'(cfg.precharge_timeout_ms)) begin
               ctl_nxt.faulted   = 1'b1;
               ctl_nxt.failed_at = ST_PRECHARGE;
               ctl_nxt.stage     = ST_COOLDOWN;
               last_ms_nxt       = now_ms;
               changed           = 1'b1;
            end
         end
         ST_CLOSING: begin
            if ((elapsed > CW'(cfg.close_settle_ms)) && fresh && hot) begin
               ctl_nxt.faulted = 1'b0;
               ctl_nxt.stage   = ST_ON;
               last_ms_nxt     = now_ms;
               changed         = 1'b1;
            end else if (elapsed > CW'(cfg.close_timeout_ms)) begin
               ctl_nxt.faulted   = 1'b1;
               ctl_nxt.failed_at = ST_CLOSING;
               ctl_nxt.stage     = ST_COOLDOWN;
               last_ms_nxt       = now_ms;
               changed           = 1'b1;
            end
         end
         ST_ON: begin
            // button wins over a fault in the same poll but keeps the fault stage
            if (lost) begin
               ctl_nxt.failed_at = ST_ON;
            end
            if (ctl_nxt.button_latch) begin
               ctl_nxt.button_latch = 1'b0;
               ctl_nxt.faulted      = 1'b0;
            end else if (lost) begin
               ctl_nxt.faulted = 1'b1;
            end
            if (ctl_nxt.button_latch != ctl_cur.button_latch || lost ||
                button_press) begin
               ctl_nxt.stage = ST_COOLDOWN;
               last_ms_nxt   = now_ms;
               changed       = 1'b1;
            end
         end
         ST_COOLDOWN: begin
            if (elapsed > CW'(cfg.cooldown_ms)) begin
               ctl_nxt.stage = ST_OFF;
               last_ms_nxt   = now_ms;
               changed       = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // result beat
   assign rsp.relay_drive   = relays;
   assign rsp.stage_now     = ctl_nxt.stage;
   assign rsp.fault_flag    = ctl_nxt.faulted;
   assign rsp.fault_stage   = ctl_nxt.failed_at;
   assign rsp.stage_changed = changed;

endmodule

// File: sv/precharge_contactor_sequencer.sv
// top level of the precharge contactor sequencer: input register, step logic, result register
// depends on pcs_pkg, pcs_req_if, pcs_rsp_if, pcs_csr and pcs_step
//
//   port      direction   role
//   req_ch    in          one poll per beat: time, button, fault request, telemetry
//   rsp_ch    out         one result beat per poll: relays, stage, fault status
//   csr_*     in/out      apb-style register access, seven registers
//
// a poll is captured in the input register, evaluated combinationally against the
// stage state, and lands in the result register; one poll per cycle while the result drains.
// the stage state updates in the same cycle a poll moves into the result register.
// a stalled result holds the result register; the input register still fills,
// and a poll is taken every cycle as long as the result side keeps draining.
// synchronous reset returns the stage to off with no fault and empties both registers.

module precharge_contactor_sequencer
   import pcs_pkg::*;
#(
   parameter int TIME_BITS = PCS_TIME_BITS,
   parameter int VOLT_BITS = PCS_VOLT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   pcs_req_if.sink               req_ch,
   pcs_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type              cfg;

   // input register
   logic                 in_valid_ff;
   logic [TIME_BITS-1:0] now_ms_ff;
   logic                 button_press_ff;
   logic                 fault_request_ff;
   logic [TIME_BITS-1:0] right_rx_ms_ff;
   logic [VOLT_BITS-1:0] right_bus_dv_ff;
   logic [TIME_BITS-1:0] left_rx_ms_ff;
   logic [VOLT_BITS-1:0] left_bus_dv_ff;

   // sequencer state
   ctl_type              ctl_ff;
   ctl_type              ctl_in;
   logic [TIME_BITS-1:0] last_ms_ff;
   logic [TIME_BITS-1:0] last_ms_in;

   // result register
   logic                 out_valid_ff;
   rsp_type              out_ff;
   rsp_type              out_in;

   logic                 advance;
   logic                 take;

   // configuration registers
   pcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // one poll of the stage rules
   pcs_step #(
      .TIME_BITS (TIME_BITS),
      .VOLT_BITS (VOLT_BITS)
   ) u_step (
      .cfg           (cfg),
      .ctl_cur       (ctl_ff),
      .last_ms_cur   (last_ms_ff),
      .now_ms        (now_ms_ff),
      .button_press  (button_press_ff),
      .fault_request (fault_request_ff),
      .right_rx_ms   (right_rx_ms_ff),
      .right_bus_dv  (right_bus_dv_ff),
      .left_rx_ms    (left_rx_ms_ff),
      .left_bus_dv   (left_bus_dv_ff),
      .ctl_nxt       (ctl_in),
      .last_ms_nxt   (last_ms_in),
      .rsp           (out_in)
   );

   // handshake: the poll moves on when the result register is free or draining
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         now_ms_ff        <= req_ch.now_ms;
         button_press_ff  <= req_ch.button_press;
         fault_request_ff <= req_ch.fault_request;
         right_rx_ms_ff   <= req_ch.right_rx_ms;
         right_bus_dv_ff  <= req_ch.right_bus_dv;
         left_rx_ms_ff    <= req_ch.left_rx_ms;
         left_bus_dv_ff   <= req_ch.left_bus_dv;
      end
   end

   // sequencer state, updated once per evaluated poll
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.stage        <= ST_OFF;
         ctl_ff.faulted      <= 1'b0;
         ctl_ff.failed_at    <= ST_OFF;
         ctl_ff.button_latch <= 1'b0;
         last_ms_ff          <= '0;
      end else if (advance) begin
         ctl_ff     <= ctl_in;
         last_ms_ff <= last_ms_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.relay_drive   = out_ff.relay_drive;
   assign rsp_ch.stage_now     = out_ff.stage_now;
   assign rsp_ch.fault_flag    = out_ff.fault_flag;
   assign rsp_ch.fault_stage   = out_ff.fault_stage;
   assign rsp_ch.stage_changed = out_ff.stage_changed;

endmodule

// File: sv/pcs_checker.sv
// port-level checks for the precharge contactor sequencer, bound to the top level
// depends on pcs_pkg and precharge_contactor_sequencer_macros.svh

`include "precharge_contactor_sequencer_macros.svh"

module pcs_checker
   import pcs_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [RELAY_W-1:0] relay_drive,
   input logic [STAGE_W-1:0] stage_now,
   input logic               fault_flag,
   input logic [STAGE_W-1:0] fault_stage,
   input logic               stage_changed
);

   logic [RELAY_W+2*STAGE_W+1:0] rsp_word;

   assign rsp_word = {relay_drive, stage_now, fault_flag, fault_stage, stage_changed};

   // a stalled result beat holds its payload
   `PCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "result beat changed while stalled")

   // nothing comes out right after reset
   `PCS_ASSERT_RAW(a_rsp_reset, $past(reset), !rsp_valid, "result beat right after reset")

   // relays only ever show one of the four stage patterns
   `PCS_ASSERT_NOW(a_relay_pattern, rsp_valid, relay_drive == RELAY_NONE || relay_drive == RELAY_PRECHARGE || relay_drive == RELAY_CLOSING || relay_drive == RELAY_ON, "unexpected relay pattern")

   // a standing fault leaves the bus down: cooldown or off only
   `PCS_ASSERT_NOW(a_fault_stage, rsp_valid && fault_flag, stage_now == ST_COOLDOWN || stage_now == ST_OFF, "fault flag set in a powered stage")

endmodule

bind precharge_contactor_sequencer pcs_checker u_pcs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .relay_drive   (rsp_ch.relay_drive),
   .stage_now     (rsp_ch.stage_now),
   .fault_flag    (rsp_ch.fault_flag),
   .fault_stage   (rsp_ch.fault_stage),
   .stage_changed (rsp_ch.stage_changed)
);
